@@ design/u8d_pkg.sv @@
`timescale 1ns / 1ps

package u8d_pkg;

   // Width of the byte position counter and of the position field.
   localparam int POS_W = 32;
   // Code point width; payload carried from the front to the back per byte.
   localparam int CP_W = 21;
   localparam int PAYLOAD_W = 7;
   localparam int CONT_BITS = 6;

   // Token queue between the classifier and the sequence engine.
   localparam int Q_DEPTH = 2;
   localparam int Q_IDX_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // What the front makes of one accepted beat.
   typedef enum logic [2:0] {
      TK_ASCII,
      TK_LEAD2,
      TK_LEAD3,
      TK_LEAD4,
      TK_CONT,
      TK_UNSUP,
      TK_EOD
   } tok_kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_STRAY       = 3'd1,
      ST_UNSUPPORTED = 3'd2,
      ST_BAD_CONT    = 3'd3,
      ST_TRUNCATED   = 3'd4
   } status_type;

   typedef struct packed {
      tok_kind_type         kind;
      logic [PAYLOAD_W-1:0] payload;
      logic [POS_W-1:0]     pos;
   } token_type;

   // Queue status seen by its producer and consumer.
   typedef struct packed {
      logic can_push;
      logic can_pop;
   } q_stat_type;

endpackage

@@ design/u8d_channels.sv @@
`timescale 1ns / 1ps

// Input channel: one byte or an end-of-data marker per beat.
interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_data;

   modport source (output valid, output byte_value, output end_of_data, input ready);
   modport sink (input valid, input byte_value, input end_of_data, output ready);
endinterface

// Result channel: one decoded code point or error report per beat.
interface u8d_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [u8d_pkg::CP_W-1:0]   code_point;
   logic [2:0]                 status;
   logic [u8d_pkg::POS_W-1:0]  byte_position;

   modport source (output valid, output code_point, output status, output byte_position,
                   input ready);
   modport sink (input valid, input code_point, input status, input byte_position,
                 output ready);
endinterface

@@ design/u8d_front.sv @@
`timescale 1ns / 1ps

module u8d_front (
   input  logic                clock,
   input  logic                reset,
   u8d_req_if.sink             req_if,
   input  u8d_pkg::q_stat_type q_stat,
   output logic                q_push,
   output u8d_pkg::token_type  q_token
);

   logic [u8d_pkg::POS_W-1:0] byte_count_ff;
   logic [u8d_pkg::POS_W-1:0] byte_count_in;
   logic                      accept;

   assign req_if.ready = q_stat.can_push;
   assign accept       = req_if.valid & req_if.ready;
   assign q_push       = accept;

   // Classify the beat and strip the marker bits off the payload.
   always_comb begin
      q_token.pos     = byte_count_ff;
      q_token.payload = '0;
      q_token.kind    = u8d_pkg::TK_UNSUP;
      if (req_if.end_of_data) begin
         q_token.kind = u8d_pkg::TK_EOD;
      end else if (!req_if.byte_value[7]) begin
         q_token.kind    = u8d_pkg::TK_ASCII;
         q_token.payload = req_if.byte_value[6:0];
      end else if (req_if.byte_value[7:6] == 2'b10) begin
         q_token.kind    = u8d_pkg::TK_CONT;
         q_token.payload = {1'b0, req_if.byte_value[5:0]};
      end else if (req_if.byte_value[7:5] == 3'b110) begin
         q_token.kind    = u8d_pkg::TK_LEAD2;
         q_token.payload = {2'b00, req_if.byte_value[4:0]};
      end else if (req_if.byte_value[7:4] == 4'b1110) begin
         q_token.kind    = u8d_pkg::TK_LEAD3;
         q_token.payload = {3'b000, req_if.byte_value[3:0]};
      end else if (req_if.byte_value[7:3] == 5'b11110) begin
         q_token.kind    = u8d_pkg::TK_LEAD4;
         q_token.payload = {4'b0000, req_if.byte_value[2:0]};
      end
   end

   // Position counter: every real byte advances it, end of data does not.
   always_comb begin
      byte_count_in = byte_count_ff;
      if (accept && !req_if.end_of_data) begin
         byte_count_in = byte_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

endmodule

@@ design/u8d_queue.sv @@
`timescale 1ns / 1ps

module u8d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u8d_pkg::token_type  push_token,
   input  logic                pop,
   output u8d_pkg::token_type  pop_token,
   output u8d_pkg::q_stat_type stat
);

   u8d_pkg::token_type          entry_ff [u8d_pkg::Q_DEPTH];
   logic [u8d_pkg::Q_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8d_pkg::Q_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8d_pkg::Q_CNT_W-1:0] count_ff, count_in;

   function automatic logic [u8d_pkg::Q_IDX_W-1:0] next_ptr(
      input logic [u8d_pkg::Q_IDX_W-1:0] ptr
   );
      if (ptr == u8d_pkg::Q_IDX_W'(u8d_pkg::Q_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign stat.can_push = (count_ff != u8d_pkg::Q_CNT_W'(u8d_pkg::Q_DEPTH));
   assign stat.can_pop  = (count_ff != '0);
   assign pop_token     = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping; push and pop may happen together.
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

@@ design/u8d_back.sv @@
`timescale 1ns / 1ps

module u8d_back (
   input  logic                clock,
   input  logic                reset,
   input  u8d_pkg::q_stat_type q_stat,
   input  u8d_pkg::token_type  q_token,
   output logic                q_pop,
   u8d_rsp_if.source           rsp_if
);

   logic [1:0]                owed_ff, owed_in;
   logic [u8d_pkg::CP_W-1:0]  partial_ff, partial_in;
   logic                      out_valid_ff, out_valid_in;
   logic [u8d_pkg::CP_W-1:0]  out_cp_ff, out_cp_in;
   u8d_pkg::status_type       out_status_ff, out_status_in;
   logic [u8d_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic                      emit;
   logic [u8d_pkg::CP_W-1:0]  shifted;

   // Take a token whenever the output register is free or being drained.
   assign q_pop   = q_stat.can_pop & (~out_valid_ff | rsp_if.ready);
   assign shifted = {partial_ff[u8d_pkg::CP_W-u8d_pkg::CONT_BITS-1:0],
                     q_token.payload[u8d_pkg::CONT_BITS-1:0]};

   // Sequence engine: continuation bytes owed and the code point so far.
   always_comb begin
      owed_in       = owed_ff;
      partial_in    = partial_ff;
      emit          = 1'b0;
      out_cp_in     = '0;
      out_status_in = u8d_pkg::ST_OK;
      if (q_pop) begin
         if (owed_ff != 2'd0) begin
            case (q_token.kind)
               u8d_pkg::TK_EOD: begin
                  emit          = 1'b1;
                  out_status_in = u8d_pkg::ST_TRUNCATED;
                  owed_in       = 2'd0;
                  partial_in    = '0;
               end
               u8d_pkg::TK_CONT: begin
                  owed_in = owed_ff - 2'd1;
                  if (owed_ff == 2'd1) begin
                     emit       = 1'b1;
                     out_cp_in  = shifted;
                     partial_in = '0;
                  end else begin
                     partial_in = shifted;
                  end
               end
               default: begin
                  emit          = 1'b1;
                  out_status_in = u8d_pkg::ST_BAD_CONT;
                  owed_in       = 2'd0;
                  partial_in    = '0;
               end
            endcase
         end else begin
            case (q_token.kind)
               u8d_pkg::TK_ASCII: begin
                  emit      = 1'b1;
                  out_cp_in = u8d_pkg::CP_W'(q_token.payload);
               end
               u8d_pkg::TK_LEAD2: begin
                  owed_in    = 2'd1;
                  partial_in = u8d_pkg::CP_W'(q_token.payload);
               end
               u8d_pkg::TK_LEAD3: begin
                  owed_in    = 2'd2;
                  partial_in = u8d_pkg::CP_W'(q_token.payload);
               end
               u8d_pkg::TK_LEAD4: begin
                  owed_in    = 2'd3;
                  partial_in = u8d_pkg::CP_W'(q_token.payload);
               end
               u8d_pkg::TK_CONT: begin
                  emit          = 1'b1;
                  out_status_in = u8d_pkg::ST_STRAY;
               end
               u8d_pkg::TK_UNSUP: begin
                  emit          = 1'b1;
                  out_status_in = u8d_pkg::ST_UNSUPPORTED;
               end
               default: begin
                  // End of data while idle: nothing to report.
                  emit = 1'b0;
               end
            endcase
         end
      end
   end

   // Output register: holds a beat until the sink takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pos_in   = q_token.pos;
      if (q_pop) begin
         out_valid_in = emit;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff      <= 2'd0;
         partial_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         owed_ff      <= owed_in;
         partial_ff   <= partial_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_cp_ff     <= out_cp_in;
         out_status_ff <= out_status_in;
         out_pos_ff    <= out_pos_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.code_point    = out_cp_ff;
   assign rsp_if.status        = out_status_ff;
   assign rsp_if.byte_position = out_pos_ff;

endmodule

@@ design/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps

// UTF-8 stream decoder.
// req_if carries one beat per byte (byte_value), or an end_of_data marker that
// carries no byte. rsp_if carries one beat for each completed code point or
// error: code_point, status (ok, stray continuation, unsupported lead, bad
// continuation, truncated) and byte_position, the index of the byte that
// finished it, or for truncation the count of bytes seen so far.
// Lead bytes and continuations that do not finish a sequence give no beat,
// nor does end of data while no sequence is pending.
// A result is registered in the token queue and then in the output register.
// Throughput: one byte per clock while rsp_if is ready; the classifier, two-entry
// token queue and sequence engine each take a beat per cycle.
// When rsp_if stalls, the output register holds its beat, the queue fills,
// and req_if.ready drops once both queue entries are taken.
// Reset (synchronous) empties the queue and the output register, clears the
// pending sequence and returns the byte position counter to zero.
module utf8_stream_decoder (
   input  logic      clock,
   input  logic      reset,
   u8d_req_if.sink   req_if,
   u8d_rsp_if.source rsp_if
);

   u8d_pkg::q_stat_type q_stat;
   u8d_pkg::token_type  push_token;
   u8d_pkg::token_type  pop_token;
   logic                q_push;
   logic                q_pop;

   u8d_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_stat  (q_stat),
      .q_push  (q_push),
      .q_token (push_token)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (push_token),
      .pop        (q_pop),
      .pop_token  (pop_token),
      .stat       (q_stat)
   );

   u8d_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_stat  (q_stat),
      .q_token (pop_token),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

   // Output register comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   // Error beats never carry a code point.
   a_err_zero_cp: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != u8d_pkg::ST_OK) |-> rsp_if.code_point == '0)
      else $error("error result with nonzero code point");

   // Status stays within the defined codes.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.status == u8d_pkg::ST_OK
                        || rsp_if.status == u8d_pkg::ST_STRAY
                        || rsp_if.status == u8d_pkg::ST_UNSUPPORTED
                        || rsp_if.status == u8d_pkg::ST_BAD_CONT
                        || rsp_if.status == u8d_pkg::ST_TRUNCATED))
      else $error("undefined status code");

   // The engine never pops an empty queue, the front never pushes a full one.
   a_queue_bounds: assert property (@(posedge clock) disable iff (reset)
      (!q_pop || q_stat.can_pop) && (!q_push || q_stat.can_push))
      else $error("token queue overrun or underrun");

endmodule
